@@ src/bss_pkg.sv @@
// bss_pkg: shared types and codes for the bounded sorted set
// operation and status codes, controller states, cell command and flag structs
// no dependencies
package bss_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SELECT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } t_cell_cmd;

    // compare results held by each cell between capture and update
    typedef struct packed {
        logic eq;
        logic lt;
        logic hit;
    } t_cell_flags;

endpackage

@@ src/bss_cell.sv @@
// bss_cell: one slot of the sorted chain
// holds one entry, compares it against the request value, shifts with neighbors
// depends on bss_pkg
module bss_cell
    import bss_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_occupied,
    input  logic                     i_sel,
    input  logic                     i_prev_lt,
    input  logic signed [DATA_W-1:0] i_prev_entry,
    input  logic signed [DATA_W-1:0] i_next_entry,
    output logic signed [DATA_W-1:0] o_entry,
    output t_cell_flags              o_flags
);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    t_cell_flags              r_flags;
    t_cell_flags              n_flags;

    always_comb begin
        n_flags = r_flags;
        if (i_cmd.capture) begin
            n_flags.eq  = i_occupied && (r_entry == i_value);
            n_flags.lt  = i_occupied && (r_entry < i_value);
            n_flags.hit = i_sel;
        end
    end

    // entries below the insert or remove point keep their place
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert && !r_flags.lt) begin
            n_entry = i_prev_lt ? i_value : i_prev_entry;
        end else if (i_cmd.remove && !r_flags.lt) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_flags <= n_flags;
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

@@ src/bounded_sorted_set_top.sv @@
// bounded_sorted_set_top: fixed-capacity sorted set built as a chain of cells
// controller, result register and the cell chain
// depends on bss_pkg and bss_cell
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order, one
// value per cell of a chain. A request carries a mode (insert, remove, find,
// select, clear), a value and a position; each request gives exactly one
// result with a status, a found position, a read value and the count after
// the operation. In the cycle a request is accepted every
// cell compares its entry against the request value and records equal /
// less-than / position-hit flags; in the update state the flags are reduced,
// and once the result register is free the cells shift toward or away from
// their neighbor to open or close a gap and the result is loaded into the
// output register. The update waits while the previous result is still held
// unread, so a slow consumer delays it. Entries hold no reset value; only
// cells below the count are ever compared or read.
module bounded_sorted_set_top
    import bss_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [DATA_W-1:0]   i_value,
    input  logic [POS_W-1:0]           i_position,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [POS_W-1:0]           o_found_position,
    output logic signed [DATA_W-1:0]   o_read_value,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // controller state
    t_state r_state;
    t_state n_state;

    // request held for the update cycle
    logic [MODE_W-1:0]        r_mode;
    logic signed [DATA_W-1:0] r_value;
    logic [POS_W-1:0]         r_position;

    // occupancy
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [POS_W-1:0]         r_found_position;
    logic signed [DATA_W-1:0] r_read_value;
    logic [CNT_W-1:0]         r_out_count;
    logic [STATUS_W-1:0]      n_status;
    logic [POS_W-1:0]         n_found_position;
    logic signed [DATA_W-1:0] n_read_value;

    // handshakes and cell control
    logic                     in_fire;
    logic                     upd_fire;
    t_cell_cmd                cell_cmd;
    logic signed [DATA_W-1:0] cmp_value;

    // chain signals
    logic signed [DATA_W-1:0] entry_q [CAPACITY];
    t_cell_flags              flags_q [CAPACITY];
    logic [CAPACITY-1:0]      eq_vec;
    logic [CAPACITY-1:0]      lt_vec;

    // reductions over the recorded flags
    logic                     found;
    logic                     full;
    logic [IDX_W-1:0]         found_idx;
    logic signed [DATA_W-1:0] sel_value;
    logic                     pos_ok;

    // ---------------------------------------------------------------
    // controller: idle until a request, then wait in update until the result register is free for the update cycle
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (upd_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        upd_fire = 1'b0;
        unique case (r_state)
            S_IDLE:   o_ready  = 1'b1;
            // the result register must be free before the set changes
            S_UPDATE: upd_fire = !r_out_valid || i_ready;
            default: begin
                o_ready  = 1'b0;
                upd_fire = 1'b0;
            end
        endcase
    end

    assign in_fire = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode     <= i_mode;
            r_value    <= i_value;
            r_position <= i_position;
        end
    end

    // ---------------------------------------------------------------
    // flag reductions: equal flags are one-hot at most, less-than flags
    // form a prefix because the chain is sorted
    // ---------------------------------------------------------------
    always_comb begin
        found_idx = '0;
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (eq_vec[i]) begin
                found_idx = found_idx | IDX_W'(i);
            end
            if (flags_q[i].hit) begin
                sel_value = sel_value | entry_q[i];
            end
        end
    end

    assign found  = |eq_vec;
    assign full   = (32'(r_count) >= 32'(CAPACITY));
    assign pos_ok = (32'(r_position) < 32'(r_count));

    // compare against the incoming value on accept, the held one on update
    assign cmp_value = (r_state == S_IDLE) ? i_value : r_value;

    always_comb begin
        cell_cmd.capture = in_fire;
        cell_cmd.insert  = upd_fire && (r_mode == MODE_INSERT) && !full && !found;
        cell_cmd.remove  = upd_fire && (r_mode == MODE_REMOVE) && found;
    end

    // ---------------------------------------------------------------
    // result and occupancy for the update cycle
    // ---------------------------------------------------------------
    always_comb begin
        n_status         = ST_OK;
        n_found_position = '0;
        n_read_value     = '0;
        n_count          = r_count;
        case (r_mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (found) begin
                    n_status = ST_DUP;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (!found) begin
                    n_status = ST_MISSING;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            MODE_FIND: begin
                if (!found) begin
                    n_status = ST_MISSING;
                end else begin
                    n_found_position = POS_W'(found_idx);
                end
            end
            MODE_SELECT: begin
                if (pos_ok) begin
                    n_read_value = sel_value;
                end else begin
                    n_status = ST_BADPOS;
                end
            end
            MODE_CLEAR: n_count = '0;
            // unused modes leave the set alone
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_status         <= n_status;
            r_found_position <= n_found_position;
            r_read_value     <= n_read_value;
            r_out_count      <= n_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found_position;
    assign o_read_value     = r_read_value;
    assign o_count          = COUNT_W'(r_out_count);

    // ---------------------------------------------------------------
    // cell chain: each cell sees its lower and upper neighbor
    // ---------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     prev_lt;
        logic signed [DATA_W-1:0] prev_entry;
        logic signed [DATA_W-1:0] next_entry;
        logic                     occupied;
        logic                     sel;

        if (g == 0) begin : g_first
            assign prev_lt    = 1'b1;
            assign prev_entry = '0;
        end else begin : g_inner
            assign prev_lt    = flags_q[g-1].lt;
            assign prev_entry = entry_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_body
            assign next_entry = entry_q[g+1];
        end

        assign occupied = (32'(g) < 32'(r_count));
        assign sel      = (32'(g) == 32'(i_position));

        bss_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cell_cmd),
            .i_value      (cmp_value),
            .i_occupied   (occupied),
            .i_sel        (sel),
            .i_prev_lt    (prev_lt),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_entry      (entry_q[g]),
            .o_flags      (flags_q[g])
        );

        assign eq_vec[g] = flags_q[g].eq;
        assign lt_vec[g] = flags_q[g].lt;
    end

`ifndef SYNTHESIS
    // occupancy never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("count above capacity");

    // entries are distinct, so at most one cell matches
    a_eq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> $onehot0(eq_vec))
        else $error("more than one cell matched");

    // sorted chain: less-than flags are a run starting at cell zero
    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> ((lt_vec & (lt_vec + CAPACITY'(1))) == '0))
        else $error("chain out of order");

    // an update always leaves a result waiting
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("update without result");
`endif

endmodule
